@@ src/id3fp_pkg.sv @@
// Shared types, constants and codes of the ID3v2 frame body parser.
package id3fp_pkg;

  localparam int SizeW = 28;
  localparam int PropW = 9;
  localparam int LenW  = 32;

  localparam logic [2:0] VER_23 = 3'd3;
  localparam logic [2:0] VER_24 = 3'd4;
  localparam logic [2:0] VER_RESET = VER_24;

  // property bit positions
  localparam int P_TAG_DISCARD  = 0;
  localparam int P_FILE_DISCARD = 1;
  localparam int P_READ_ONLY    = 2;
  localparam int P_GROUPED      = 3;
  localparam int P_COMPRESSED   = 4;
  localparam int P_ENCRYPTED    = 5;
  localparam int P_LENGTH       = 6;
  localparam int P_UNSYNC       = 7;
  localparam int P_CORRUPT      = 8;

  // active extra-field bits
  localparam int A_GROUP  = 0;
  localparam int A_METHOD = 1;
  localparam int A_LENGTH = 2;

  typedef enum logic [1:0] {
    KIND_SUMMARY = 2'd0,
    KIND_EXTRA   = 2'd1,
    KIND_PAYLOAD = 2'd2,
    KIND_END     = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    FLD_GROUP  = 2'd0,
    FLD_METHOD = 2'd1,
    FLD_LENGTH = 2'd2,
    FLD_NONE   = 2'd3
  } field_e;

  // classified word passed from front to back
  typedef struct packed {
    logic             is_start;
    logic [PropW-1:0] props;
    logic             compressed;
    logic [2:0]       need;
    logic [2:0]       active;
    logic             unsync;
    logic [SizeW-1:0] size;
    logic [7:0]       data;
  } op_t;

  typedef struct packed {
    kind_e            kind;
    logic             last;
    logic [7:0]       payload;
    logic [PropW-1:0] props;
    logic [7:0]       group;
    logic [7:0]       method;
    logic [LenW-1:0]  length;
    logic             unsup;
  } res_t;

endpackage

@@ src/id3fp_front.sv @@
// Front stage: decodes frame-start flags for the tag version and classifies each word.
module id3fp_front (
  input  logic             mode_i,
  input  logic [15:0]      frame_flags_i,
  input  logic [27:0]      frame_size_i,
  input  logic [7:0]       data_byte_i,
  input  logic [2:0]       tag_version_i,
  output id3fp_pkg::op_t   op_o
);

  logic v3, v4;
  logic td, fd, ro, gr, co, en, dl, un, bad;
  logic [2:0] need_raw;

  always_comb begin
    v3 = (tag_version_i == id3fp_pkg::VER_23);
    v4 = (tag_version_i == id3fp_pkg::VER_24);
    td = 1'b0; fd = 1'b0; ro = 1'b0; gr = 1'b0; co = 1'b0;
    en = 1'b0; dl = 1'b0; un = 1'b0;
    if (v3) begin
      td = frame_flags_i[15];
      fd = frame_flags_i[14];
      ro = frame_flags_i[13];
      co = frame_flags_i[7];
      en = frame_flags_i[6];
      gr = frame_flags_i[5];
      dl = frame_flags_i[7];
    end else if (v4) begin
      td = frame_flags_i[14];
      fd = frame_flags_i[13];
      ro = frame_flags_i[12];
      gr = frame_flags_i[6];
      co = frame_flags_i[3];
      en = frame_flags_i[2];
      un = frame_flags_i[1];
      dl = frame_flags_i[0];
    end
    need_raw = {2'b00, gr} + {2'b00, en} + (dl ? 3'd4 : 3'd0);
    // extras longer than the body: drop them and flag the frame
    bad = ({25'd0, need_raw} > frame_size_i);

    op_o.is_start   = ~mode_i;
    op_o.props      = '0;
    op_o.props[id3fp_pkg::P_TAG_DISCARD]  = td;
    op_o.props[id3fp_pkg::P_FILE_DISCARD] = fd;
    op_o.props[id3fp_pkg::P_READ_ONLY]    = ro;
    op_o.props[id3fp_pkg::P_GROUPED]      = gr & ~bad;
    op_o.props[id3fp_pkg::P_COMPRESSED]   = co;
    op_o.props[id3fp_pkg::P_ENCRYPTED]    = en & ~bad;
    op_o.props[id3fp_pkg::P_LENGTH]       = dl & ~bad;
    op_o.props[id3fp_pkg::P_UNSYNC]       = un;
    op_o.props[id3fp_pkg::P_CORRUPT]      = bad;
    op_o.compressed = co;
    op_o.need       = bad ? 3'd0 : need_raw;
    op_o.active     = bad ? 3'd0 : {dl, en, gr};
    op_o.unsync     = un;
    op_o.size       = frame_size_i;
    op_o.data       = data_byte_i;
  end

endmodule

@@ src/id3fp_queue.sv @@
// Two-entry queue of classified words between the front and back stages.
module id3fp_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  id3fp_pkg::op_t push_op_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output id3fp_pkg::op_t pop_op_o
);

  id3fp_pkg::op_t mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;

  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_op_i;
    end
  end

  assign full_o   = (count_q == 2'd2);
  assign valid_o  = (count_q != 2'd0);
  assign pop_op_o = mem_q[rd_ptr_q];

endmodule

@@ src/id3fp_back.sv @@
// Back stage: frame state, extra-field capture, unsync removal and the result register.
module id3fp_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic [2:0]     tag_version_i,
  input  logic           op_valid_i,
  input  id3fp_pkg::op_t op_i,
  output logic           op_pop_o,
  output logic           res_valid_o,
  output id3fp_pkg::res_t res_o,
  input  logic           res_ready_i
);

  logic        frame_open_q, frame_open_d;
  logic [27:0] bytes_left_q, bytes_left_d;
  logic [2:0]  extra_index_q, extra_index_d;
  logic [2:0]  extra_total_q, extra_total_d;
  logic [2:0]  active_q, active_d;
  logic [7:0]  held_group_q, held_group_d;
  logic [7:0]  held_method_q, held_method_d;
  logic [31:0] held_length_q, held_length_d;
  logic        unsync_q, unsync_d;
  logic        prev_ff_q, prev_ff_d;

  logic            res_valid_q, res_valid_d;
  id3fp_pkg::res_t res_q, res_d;
  logic            has_res;
  logic            last;
  logic            v3, v4;
  id3fp_pkg::field_e fld;

  // which extra field byte k belongs to, in the order of the version
  function automatic id3fp_pkg::field_e field_at(input logic [2:0] k, input logic [2:0] act,
                                                 input logic is_v3);
    id3fp_pkg::field_e ord [3];
    id3fp_pkg::field_e res;
    logic [3:0] pos;
    logic [3:0] w;
    logic       hit;
    if (is_v3) begin
      ord[0] = id3fp_pkg::FLD_LENGTH;
      ord[1] = id3fp_pkg::FLD_METHOD;
      ord[2] = id3fp_pkg::FLD_GROUP;
    end else begin
      ord[0] = id3fp_pkg::FLD_GROUP;
      ord[1] = id3fp_pkg::FLD_METHOD;
      ord[2] = id3fp_pkg::FLD_LENGTH;
    end
    res = id3fp_pkg::FLD_NONE;
    pos = 4'd0;
    hit = 1'b0;
    for (int i = 0; i < 3; i++) begin
      if (act[ord[i]]) begin
        w = (ord[i] == id3fp_pkg::FLD_LENGTH) ? 4'd4 : 4'd1;
        if (!hit && ({1'b0, k} < pos + w)) begin
          res = ord[i];
          hit = 1'b1;
        end
        pos = pos + w;
      end
    end
    return res;
  endfunction

  assign op_pop_o = op_valid_i & (~res_valid_q | res_ready_i);

  always_comb begin
    v3 = (tag_version_i == id3fp_pkg::VER_23);
    v4 = (tag_version_i == id3fp_pkg::VER_24);
    frame_open_d  = frame_open_q;
    bytes_left_d  = bytes_left_q;
    extra_index_d = extra_index_q;
    extra_total_d = extra_total_q;
    active_d      = active_q;
    held_group_d  = held_group_q;
    held_method_d = held_method_q;
    held_length_d = held_length_q;
    unsync_d      = unsync_q;
    prev_ff_d     = prev_ff_q;
    has_res       = 1'b0;
    last          = 1'b0;
    fld           = field_at(extra_index_q, active_q, v3);
    res_d         = '0;

    if (op_i.is_start) begin
      active_d      = op_i.active;
      extra_total_d = op_i.need;
      extra_index_d = 3'd0;
      held_group_d  = 8'd0;
      held_method_d = 8'd0;
      held_length_d = 32'd0;
      unsync_d      = op_i.unsync;
      prev_ff_d     = 1'b0;
      bytes_left_d  = op_i.size;
      frame_open_d  = (op_i.size != 28'd0);
      has_res       = 1'b1;
      res_d.kind    = id3fp_pkg::KIND_SUMMARY;
      res_d.last    = (op_i.size == 28'd0);
      res_d.props   = op_i.props;
      res_d.unsup   = op_i.compressed;
    end else if (frame_open_q) begin
      bytes_left_d = bytes_left_q - 28'd1;
      last = (bytes_left_d == 28'd0);
      if (last) begin
        frame_open_d = 1'b0;
      end
      if (extra_index_q < extra_total_q) begin
        case (fld)
          id3fp_pkg::FLD_GROUP:  held_group_d = op_i.data;
          id3fp_pkg::FLD_METHOD: held_method_d = op_i.data;
          id3fp_pkg::FLD_LENGTH: begin
            held_length_d = v4 ? {held_length_q[24:0], op_i.data[6:0]}
                               : {held_length_q[23:0], op_i.data};
          end
          default: ;
        endcase
        extra_index_d = extra_index_q + 3'd1;
        if (extra_index_d == extra_total_q) begin
          has_res      = 1'b1;
          res_d.kind   = id3fp_pkg::KIND_EXTRA;
          res_d.last   = last;
          res_d.group  = held_group_d;
          res_d.method = held_method_d;
          res_d.length = held_length_d;
        end else if (last) begin
          has_res    = 1'b1;
          res_d.kind = id3fp_pkg::KIND_END;
          res_d.last = 1'b1;
        end
      end else if (unsync_q && prev_ff_q && (op_i.data == 8'h00)) begin
        // drop the stuffed zero
        prev_ff_d = 1'b0;
        if (last) begin
          has_res    = 1'b1;
          res_d.kind = id3fp_pkg::KIND_END;
          res_d.last = 1'b1;
        end
      end else begin
        prev_ff_d     = (op_i.data == 8'hFF);
        has_res       = 1'b1;
        res_d.kind    = id3fp_pkg::KIND_PAYLOAD;
        res_d.last    = last;
        res_d.payload = op_i.data;
      end
    end

    if (op_pop_o) begin
      res_valid_d = has_res;
    end else if (res_ready_i) begin
      res_valid_d = 1'b0;
    end else begin
      res_valid_d = res_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_open_q  <= 1'b0;
      bytes_left_q  <= '0;
      extra_index_q <= '0;
      extra_total_q <= '0;
      active_q      <= '0;
      held_group_q  <= '0;
      held_method_q <= '0;
      held_length_q <= '0;
      unsync_q      <= 1'b0;
      prev_ff_q     <= 1'b0;
      res_valid_q   <= 1'b0;
    end else begin
      res_valid_q <= res_valid_d;
      if (op_pop_o) begin
        frame_open_q  <= frame_open_d;
        bytes_left_q  <= bytes_left_d;
        extra_index_q <= extra_index_d;
        extra_total_q <= extra_total_d;
        active_q      <= active_d;
        held_group_q  <= held_group_d;
        held_method_q <= held_method_d;
        held_length_q <= held_length_d;
        unsync_q      <= unsync_d;
        prev_ff_q     <= prev_ff_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (op_pop_o && has_res) begin
      res_q <= res_d;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

@@ src/id3v2_frame_body_parser.sv @@
// Top level of the ID3v2 frame body parser: ports, version register, stages and checks.
//
// Takes one word per cycle, sustained, while results are taken as they come: a
// frame-start word gives a flag summary, body words give the extra fields once all
// of their bytes are in and then the payload with unsync zeros removed. A word
// passes the combinational front decoder into a two-entry queue and is then carried
// out by the back stage, whose result register lets the input side keep running
// while a result waits. The user must write the tag version register over the cfg
// channel only while idle; the block does not enforce this.
module id3v2_frame_body_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_data_i,    // tag_version
  input  logic        s_tvalid_i,
  output logic        s_tready_o,
  input  logic [55:0] s_tdata_i,     // frame_flags[15:0], frame_size[43:16], data_byte[51:44]
  input  logic [0:0]  s_tuser_i,     // mode[0]
  output logic        m_tvalid_o,
  input  logic        m_tready_i,
  output logic [71:0] m_tdata_o,     // payload_byte[7:0], properties[16:8], group_id[24:17],
                                     // encryption_method[32:25], data_length[64:33],
                                     // unsupported_compression[65]
  output logic [1:0]  m_tuser_o,     // kind[1:0]
  output logic        m_tlast_o      // last_of_frame
);

  logic [2:0]      tag_q;
  id3fp_pkg::op_t  front_op;
  id3fp_pkg::op_t  q_op;
  logic            q_full, q_valid, q_pop;
  id3fp_pkg::res_t res;
  logic            res_valid;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q <= id3fp_pkg::VER_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      tag_q <= cfg_data_i;
    end
  end

  id3fp_front u_front (
    .mode_i        (s_tuser_i[0]),
    .frame_flags_i (s_tdata_i[15:0]),
    .frame_size_i  (s_tdata_i[43:16]),
    .data_byte_i   (s_tdata_i[51:44]),
    .tag_version_i (tag_q),
    .op_o          (front_op)
  );

  assign s_tready_o = ~q_full;

  id3fp_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (s_tvalid_i & s_tready_o),
    .push_op_i (front_op),
    .full_o    (q_full),
    .pop_i     (q_pop),
    .valid_o   (q_valid),
    .pop_op_o  (q_op)
  );

  id3fp_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .tag_version_i (tag_q),
    .op_valid_i    (q_valid),
    .op_i          (q_op),
    .op_pop_o      (q_pop),
    .res_valid_o   (res_valid),
    .res_o         (res),
    .res_ready_i   (m_tready_i)
  );

  assign m_tvalid_o = res_valid;
  assign m_tuser_o  = res.kind;
  assign m_tlast_o  = res.last;
  assign m_tdata_o  = {6'd0, res.unsup, res.length, res.method, res.group,
                       res.props, res.payload};

  // extra fields only travel with the extra-fields result
  a_extra_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && (res.kind != id3fp_pkg::KIND_EXTRA) |->
      (res.group == 8'd0) && (res.method == 8'd0) && (res.length == 32'd0))
    else $error("extra fields set outside an extra-fields result");

  a_summary_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && (res.kind != id3fp_pkg::KIND_SUMMARY) |->
      (res.props == '0) && !res.unsup)
    else $error("flag properties set outside a summary");

  a_end_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && (res.kind == id3fp_pkg::KIND_END) |-> m_tlast_o)
    else $error("frame end result without last");

  a_cfg_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i && cfg_ready_o |=> tag_q == $past(cfg_data_i))
    else $error("tag version write lost");

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench of the ID3v2 frame body parser with an in-line predictor.
`timescale 1ns / 100ps

import id3fp_pkg::*;

class parse_scoreboard;
  // frame flag masks per tag version
  localparam logic [15:0] V3_TAG_DISCARD  = 16'h8000;
  localparam logic [15:0] V3_FILE_DISCARD = 16'h4000;
  localparam logic [15:0] V3_READ_ONLY    = 16'h2000;
  localparam logic [15:0] V3_COMPRESSED   = 16'h0080;
  localparam logic [15:0] V3_ENCRYPTED    = 16'h0040;
  localparam logic [15:0] V3_GROUPED      = 16'h0020;
  localparam logic [15:0] V4_TAG_DISCARD  = 16'h4000;
  localparam logic [15:0] V4_FILE_DISCARD = 16'h2000;
  localparam logic [15:0] V4_READ_ONLY    = 16'h1000;
  localparam logic [15:0] V4_GROUPED      = 16'h0040;
  localparam logic [15:0] V4_COMPRESSED   = 16'h0008;
  localparam logic [15:0] V4_ENCRYPTED    = 16'h0004;
  localparam logic [15:0] V4_UNSYNC       = 16'h0002;
  localparam logic [15:0] V4_LENGTH       = 16'h0001;
  localparam bit MODE_START = 1'b0;

  logic [2:0]       version;
  bit               frame_open;
  logic [SizeW-1:0] bytes_due;
  int unsigned      field_pos;
  int unsigned      field_count;
  logic [2:0]       field_mask;
  logic [7:0]       grp_byte;
  logic [7:0]       method_byte;
  logic [LenW-1:0]  length_acc;
  bit               unsync_on;
  bit               after_ff;
  res_t             results_due[$];
  int unsigned      errors;

  function new();
    version     = VER_RESET;
    frame_open  = 0;
    bytes_due   = '0;
    field_pos   = 0;
    field_count = 0;
    field_mask  = '0;
    grp_byte    = '0;
    method_byte = '0;
    length_acc  = '0;
    unsync_on   = 0;
    after_ff    = 0;
    errors      = 0;
  endfunction

  function int pending();
    return results_due.size();
  endfunction

  // which extra field the k-th extra byte belongs to, in the current version's order
  function field_e field_at(int unsigned k);
    field_e      order[3];
    int unsigned pos;
    int unsigned w;
    pos = 0;
    if (version == VER_23) order = '{FLD_LENGTH, FLD_METHOD, FLD_GROUP};
    else order = '{FLD_GROUP, FLD_METHOD, FLD_LENGTH};
    foreach (order[i]) begin
      // field codes line up with the active-field bit positions
      if (field_mask[int'(order[i])]) begin
        w = (order[i] == FLD_LENGTH) ? 4 : 1;
        if (k < pos + w) return order[i];
        pos += w;
      end
    end
    return FLD_NONE;
  endfunction

  function void predict_word(bit mode, logic [15:0] fl, logic [SizeW-1:0] sz, logic [7:0] b);
    res_t        r;
    int unsigned need;
    bit          last;
    r = '0;
    if (mode == MODE_START) begin
      if (version == VER_23) begin
        r.props[P_TAG_DISCARD]  = |(fl & V3_TAG_DISCARD);
        r.props[P_FILE_DISCARD] = |(fl & V3_FILE_DISCARD);
        r.props[P_READ_ONLY]    = |(fl & V3_READ_ONLY);
        r.props[P_COMPRESSED]   = |(fl & V3_COMPRESSED);
        r.props[P_ENCRYPTED]    = |(fl & V3_ENCRYPTED);
        r.props[P_GROUPED]      = |(fl & V3_GROUPED);
        r.props[P_LENGTH]       = |(fl & V3_COMPRESSED);
      end else if (version == VER_24) begin
        r.props[P_TAG_DISCARD]  = |(fl & V4_TAG_DISCARD);
        r.props[P_FILE_DISCARD] = |(fl & V4_FILE_DISCARD);
        r.props[P_READ_ONLY]    = |(fl & V4_READ_ONLY);
        r.props[P_GROUPED]      = |(fl & V4_GROUPED);
        r.props[P_COMPRESSED]   = |(fl & V4_COMPRESSED);
        r.props[P_ENCRYPTED]    = |(fl & V4_ENCRYPTED);
        r.props[P_UNSYNC]       = |(fl & V4_UNSYNC);
        r.props[P_LENGTH]       = |(fl & V4_LENGTH);
      end
      need = (r.props[P_GROUPED] ? 1 : 0) + (r.props[P_ENCRYPTED] ? 1 : 0)
           + (r.props[P_LENGTH] ? 4 : 0);
      // extras longer than the body: drop them and flag the frame
      if (need > sz) begin
        r.props[P_GROUPED]   = 1'b0;
        r.props[P_ENCRYPTED] = 1'b0;
        r.props[P_LENGTH]    = 1'b0;
        r.props[P_CORRUPT]   = 1'b1;
        need = 0;
      end
      field_mask[A_GROUP]  = r.props[P_GROUPED];
      field_mask[A_METHOD] = r.props[P_ENCRYPTED];
      field_mask[A_LENGTH] = r.props[P_LENGTH];
      field_count = need;
      field_pos   = 0;
      grp_byte    = '0;
      method_byte = '0;
      length_acc  = '0;
      unsync_on   = r.props[P_UNSYNC];
      after_ff    = 0;
      bytes_due   = sz;
      frame_open  = (sz != 0);
      r.kind  = KIND_SUMMARY;
      r.last  = (sz == 0);
      r.unsup = r.props[P_COMPRESSED];
      results_due.push_back(r);
      return;
    end

    if (!frame_open) return;
    bytes_due = bytes_due - 1'b1;
    last = (bytes_due == 0);
    if (last) frame_open = 0;

    if (field_pos < field_count) begin
      case (field_at(field_pos))
        FLD_GROUP:  grp_byte = b;
        FLD_METHOD: method_byte = b;
        FLD_LENGTH: begin
          if (version == VER_24) length_acc = {length_acc[LenW-8:0], b[6:0]};
          else length_acc = {length_acc[LenW-9:0], b};
        end
        default: ;
      endcase
      field_pos++;
      if (field_pos == field_count) begin
        r.kind   = KIND_EXTRA;
        r.last   = last;
        r.group  = grp_byte;
        r.method = method_byte;
        r.length = length_acc;
        results_due.push_back(r);
      end else if (last) begin
        r.kind = KIND_END;
        r.last = 1'b1;
        results_due.push_back(r);
      end
      return;
    end

    // drop a zero that follows an emitted FF
    if (unsync_on && after_ff && b == 8'h00) begin
      after_ff = 0;
      if (last) begin
        r.kind = KIND_END;
        r.last = 1'b1;
        results_due.push_back(r);
      end
      return;
    end
    after_ff  = (b == 8'hFF);
    r.kind    = KIND_PAYLOAD;
    r.last    = last;
    r.payload = b;
    results_due.push_back(r);
  endfunction

  function void compare(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      errors++;
    end
  endfunction

  function void check_result(res_t got);
    res_t want;
    if (results_due.size() == 0) begin
      $error("result with nothing expected: kind %0d", got.kind);
      errors++;
      return;
    end
    want = results_due.pop_front();
    compare("kind", want.kind, got.kind);
    compare("last_of_frame", want.last, got.last);
    compare("payload_byte", want.payload, got.payload);
    compare("properties", want.props, got.props);
    compare("group_id", want.group, got.group);
    compare("encryption_method", want.method, got.method);
    compare("data_length", want.length, got.length);
    compare("unsupported_compression", want.unsup, got.unsup);
  endfunction
endclass

module tb_top;
  localparam bit          MODE_START      = 1'b0;
  localparam bit          MODE_BYTE       = 1'b1;
  localparam int          DRAIN_CYCLES    = 8;
  localparam int          WORDS_PER_PHASE = 104;
  localparam longint      TIMEOUT_NS      = 2_000_000;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [2:0]  cfg_data_i;
  logic        s_tvalid_i;
  logic        s_tready_o;
  logic [55:0] s_tdata_i;   // frame_flags[15:0], frame_size[43:16], data_byte[51:44]
  logic [0:0]  s_tuser_i;   // mode[0]
  logic        m_tvalid_o;
  logic        m_tready_i;
  logic [71:0] m_tdata_o;   // payload_byte, properties, group_id, encryption_method,
                            // data_length, unsupported_compression
  logic [1:0]  m_tuser_o;   // kind[1:0]
  logic        m_tlast_o;

  parse_scoreboard sb = new();
  bit              idle_en = 1'b1;
  int unsigned     words_sent = 0;

  id3v2_frame_body_parser dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .s_tvalid_i  (s_tvalid_i),
    .s_tready_o  (s_tready_o),
    .s_tdata_i   (s_tdata_i),
    .s_tuser_i   (s_tuser_i),
    .m_tvalid_o  (m_tvalid_o),
    .m_tready_i  (m_tready_i),
    .m_tdata_o   (m_tdata_o),
    .m_tuser_o   (m_tuser_o),
    .m_tlast_o   (m_tlast_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("TB_ERROR");
    $finish;
  end

  // all task calls start and end on a rising edge; valid stays high across back-to-back words
  task automatic send_word(bit mode, logic [15:0] fl, logic [SizeW-1:0] sz, logic [7:0] b);
    int unsigned gap;
    gap = idle_en ? $urandom_range(0, 4) : 0;
    if (gap != 0) begin
      s_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid_i <= 1'b1;
    s_tdata_i  <= {4'b0, b, sz, fl};
    s_tuser_i  <= mode;
    do @(posedge clk_i); while (!s_tready_o);
    sb.predict_word(mode, fl, sz, b);
    words_sent++;
  endtask

  task automatic send_start(logic [15:0] fl, logic [SizeW-1:0] sz);
    send_word(MODE_START, fl, sz, 8'($urandom));
  endtask

  task automatic send_byte(logic [7:0] b);
    send_word(MODE_BYTE, 16'($urandom), SizeW'($urandom), b);
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 3))
      0: return 8'hFF;
      1: return 8'h00;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic send_random_frame();
    int unsigned      shape;
    int unsigned      n;
    logic [SizeW-1:0] sz;
    shape = $urandom_range(0, 99);
    if (shape < 88) sz = SizeW'($urandom_range(0, 12));
    else if (shape < 96) sz = SizeW'($urandom_range(13, 40));
    else sz = SizeW'($urandom);
    send_start(16'($urandom), sz);
    if (shape < 80 || (shape >= 88 && shape < 96)) n = 32'(sz);
    else if (shape < 88) n = $urandom_range(0, int'(sz));  // may end short; the next start abandons it
    else n = $urandom_range(0, 6);
    repeat (n) send_byte(pick_byte());
    if ($urandom_range(0, 9) == 0) repeat ($urandom_range(1, 3)) send_byte(pick_byte());
  endtask

  // hold input until every expected word is out, then let the pipe settle
  task automatic drain();
    s_tvalid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_version(logic [2:0] v);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.version = v;
  endtask

  // result side: random stall before each word, sampled at the accepting edge
  initial begin
    int unsigned stall;
    res_t        got;
    m_tready_i = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      stall = idle_en ? $urandom_range(0, 4) : 0;
      if (stall != 0) begin
        m_tready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_tready_i <= 1'b1;
      do @(posedge clk_i); while (!m_tvalid_o);
      got.kind    = kind_e'(m_tuser_o);
      got.last    = m_tlast_o;
      got.payload = m_tdata_o[7:0];
      got.props   = m_tdata_o[16:8];
      got.group   = m_tdata_o[24:17];
      got.method  = m_tdata_o[32:25];
      got.length  = m_tdata_o[64:33];
      got.unsup   = m_tdata_o[65];
      sb.check_result(got);
    end
  end

  initial begin
    logic [2:0]  version_plan [14];
    int unsigned phase_end;
    version_plan = '{VER_23, 3'd2, VER_24, 3'd0, VER_23, 3'd7, VER_24,
                     3'd1, VER_23, 3'd5, 3'd6, VER_24, 3'd2, VER_23};
    rst_ni      = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_data_i  = '0;
    s_tvalid_i  = 1'b0;
    s_tdata_i   = '0;
    s_tuser_i   = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    write_version(VER_24);

    // every 2.4 flag set: group, method, synchsafe length, then an FF 00 ending the body
    send_start(16'hFFFF, 8);
    send_byte(8'hAB);
    send_byte(8'h00);
    send_byte(8'h7F);
    send_byte(8'hFF);
    send_byte(8'h80);
    send_byte(8'h01);
    send_byte(8'hFF);
    send_byte(8'h00);
    // length flag with a body too short for it
    send_start(16'h0001, 3);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(8'h00);
    // empty frame, then a stray byte outside any frame
    send_start(16'h0000, 0);
    send_byte(8'h55);
    // unsync frame of maximum size, abandoned by the next start
    send_start(16'h0002, {SizeW{1'b1}});
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_start(16'h0000, 1);
    send_byte(8'h00);

    foreach (version_plan[ph]) begin
      drain();
      write_version(version_plan[ph]);
      idle_en = (ph % 3 != 2);
      phase_end = words_sent + WORDS_PER_PHASE;
      while (words_sent < phase_end) send_random_frame();
    end

    drain();
    if (sb.errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end
endmodule
